// ===== rtl/core/hci_reset_init_sequencer_defines.svh =====
// Assertion macros used by the sequencer back end
`ifndef HCI_RESET_INIT_SEQUENCER_DEFINES_SVH
`define HCI_RESET_INIT_SEQUENCER_DEFINES_SVH

// clocked check, off while reset is asserted
`define HCIS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define HCIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hcis_pkg.sv =====
// Types, codes and constants of the HCI reset and initialisation sequencer
`timescale 1ns / 1ps
package hcis_pkg;

  localparam logic [7:0]  EVT_CMD_COMPLETE = 8'h0e;
  localparam logic [1:0]  RANDOM_ROUNDS    = 2'd3;
  localparam logic [31:0] RF_POWER_LEVEL   = 32'd6;
  localparam int unsigned CMDQ_DEPTH       = 4;
  localparam int unsigned CMDQ_PTR_W       = $clog2(CMDQ_DEPTH);
  localparam int unsigned CFG_IDX_W        = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HOST_FEATURES    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED_PRESENT = 1'd1;

  localparam logic [15:0] OP_SET_EVMASK     = 16'h0c01;
  localparam logic [15:0] OP_RESET          = 16'h0c03;
  localparam logic [15:0] OP_SET_EVMASK_P2  = 16'h0c63;
  localparam logic [15:0] OP_READ_VERSION   = 16'h1001;
  localparam logic [15:0] OP_READ_BDADDR    = 16'h1009;
  localparam logic [15:0] OP_LE_EVMASK      = 16'h2001;
  localparam logic [15:0] OP_LE_BUFSIZE     = 16'h2002;
  localparam logic [15:0] OP_LE_FEATURES    = 16'h2003;
  localparam logic [15:0] OP_LE_WLSIZE      = 16'h200f;
  localparam logic [15:0] OP_LE_RAND        = 16'h2018;
  localparam logic [15:0] OP_LE_STATES      = 16'h201c;
  localparam logic [15:0] OP_LE_MAXLEN      = 16'h2024;
  localparam logic [15:0] OP_LE_RLSIZE      = 16'h202a;
  localparam logic [15:0] OP_LE_RDDEFLEN    = 16'h202f;
  localparam logic [15:0] OP_LE_MAXADVLEN   = 16'h203a;
  localparam logic [15:0] OP_LE_NUMADVSETS  = 16'h203b;
  localparam logic [15:0] OP_LE_PERLISTSIZE = 16'h204a;
  localparam logic [15:0] OP_VS_NVDS        = 16'hfcc4;
  localparam logic [15:0] OP_VS_RFPOWER     = 16'hfff2;

  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_HANDOFF = 2'd1,
    ACT_DONE    = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ID_RESET       = 4'd0,
    ID_VS_BDADDR   = 4'd1,
    ID_VS_NVDS     = 4'd2,
    ID_VS_RFPOWER  = 4'd3,
    ID_EVMASK      = 4'd4,
    ID_LE_EVMASK   = 4'd5,
    ID_EVMASK_P2   = 4'd6,
    ID_READ_BDADDR = 4'd7,
    ID_LE_BUFSIZE  = 4'd8,
    ID_LE_STATES   = 4'd9,
    ID_LE_WLSIZE   = 4'd10,
    ID_LE_FEATURES = 4'd11,
    ID_LE_RLSIZE   = 4'd12,
    ID_LE_MAXLEN   = 4'd13,
    ID_LE_RAND     = 4'd14,
    ID_LE_WRDEFLEN = 4'd15
  } cmd_id_e;

  typedef enum logic [2:0] {
    CLS_START,
    CLS_FIXED,
    CLS_RESET_DONE,
    CLS_FEATURES,
    CLS_RLSIZE,
    CLS_RAND,
    CLS_MAXLEN,
    CLS_HANDOFF
  } cls_e;

  typedef struct packed {
    logic        func;
    logic [7:0]  event_code;
    logic [15:0] cmd_opcode;
    logic [63:0] return_params;
  } item_t;

  typedef struct packed {
    action_e     action;
    cmd_id_e     command_id;
    logic [31:0] command_arg;
    logic [15:0] handoff_opcode;
    logic        last;
  } result_t;

  typedef struct packed {
    cls_e        cls;
    cmd_id_e     cmd_id;
    logic [31:0] arg;
    logic [15:0] opcode;
    logic [63:0] data;
  } cmd_t;

endpackage

// ===== rtl/core/hci_reset_init_sequencer.sv =====
// Top level of the HCI reset and initialisation sequencer
//
//  channel   handshake                 payload
//  input     push_i / full_o           item_i   (func, event_code, cmd_opcode, return_params)
//  result    pop_i / empty_o           result_o (action, command_id, command_arg,
//                                                handoff_opcode, last)
//  config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A result is registered in the command queue and then in the result queue before
// it shows on result_o, where it can be popped. Other event codes and unknown opcodes
// are dropped at entry. The back end retires one entry per cycle while the result
// queue has room; a start item stays at the head until both its results are out.
// Reset clears all sequencing state and both queues; configuration is always ready.
// full_o rises after four entries wait; the back end stalls while two results wait.
`timescale 1ns / 1ps
module hci_reset_init_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  hcis_pkg::item_t                item_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output hcis_pkg::result_t              result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hcis_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                    cfg_data_i
);
  import hcis_pkg::*;

  logic keep, cmd_valid, cmd_pop;
  cmd_t front_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  hcis_front u_front (
    .item_i (item_i),
    .keep_o (keep),
    .cmd_o  (front_cmd)
  );

  hcis_cmd_fifo u_cmdq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push_i && keep),
    .wr_data_i (front_cmd),
    .full_o    (full_o),
    .rd_i      (cmd_pop),
    .valid_o   (cmd_valid),
    .rd_data_o (head_cmd)
  );

  hcis_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .result_o    (result_o)
  );

endmodule

// ===== rtl/core/hcis_front.sv =====
// Front end: classify start items and completed opcodes into queue entries
`timescale 1ns / 1ps
module hcis_front (
  input  hcis_pkg::item_t item_i,
  output logic            keep_o,
  output hcis_pkg::cmd_t  cmd_o
);
  import hcis_pkg::*;

  always_comb begin
    keep_o        = 1'b1;
    cmd_o         = '0;
    cmd_o.cls     = CLS_FIXED;
    cmd_o.cmd_id  = ID_RESET;
    cmd_o.opcode  = item_i.cmd_opcode;
    cmd_o.data    = item_i.return_params;
    if (!item_i.func) begin
      cmd_o.cls = CLS_START;
    end else if (item_i.event_code != EVT_CMD_COMPLETE) begin
      keep_o = 1'b0;
    end else begin
      unique case (item_i.cmd_opcode)
        OP_SET_EVMASK:    cmd_o.cmd_id = ID_LE_EVMASK;
        OP_RESET:         cmd_o.cls    = CLS_RESET_DONE;
        OP_SET_EVMASK_P2: cmd_o.cmd_id = ID_READ_BDADDR;
        OP_READ_BDADDR:   cmd_o.cmd_id = ID_LE_BUFSIZE;
        OP_LE_EVMASK:     cmd_o.cmd_id = ID_EVMASK_P2;
        OP_LE_BUFSIZE:    cmd_o.cmd_id = ID_LE_STATES;
        OP_LE_FEATURES:   cmd_o.cls    = CLS_FEATURES;
        OP_LE_WLSIZE:     cmd_o.cmd_id = ID_LE_FEATURES;
        OP_LE_RAND:       cmd_o.cls    = CLS_RAND;
        OP_LE_STATES:     cmd_o.cmd_id = ID_LE_WLSIZE;
        OP_LE_MAXLEN:     cmd_o.cls    = CLS_MAXLEN;
        OP_LE_RLSIZE:     cmd_o.cls    = CLS_RLSIZE;
        OP_LE_RDDEFLEN: begin
          cmd_o.cmd_id = ID_LE_WRDEFLEN;
          cmd_o.arg    = item_i.return_params[31:0];
        end
        OP_VS_NVDS:       cmd_o.cmd_id = ID_EVMASK;
        OP_VS_RFPOWER: begin
          cmd_o.cmd_id = ID_VS_RFPOWER;
          cmd_o.arg    = RF_POWER_LEVEL;
        end
        OP_READ_VERSION, OP_LE_MAXADVLEN, OP_LE_NUMADVSETS, OP_LE_PERLISTSIZE:
          cmd_o.cls = CLS_HANDOFF;
        default:          keep_o = 1'b0;
      endcase
    end
  end

endmodule

// ===== rtl/core/hcis_cmd_fifo.sv =====
// Short command queue between front end and back end
`timescale 1ns / 1ps
module hcis_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  hcis_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           valid_o,
  output hcis_pkg::cmd_t rd_data_o
);
  import hcis_pkg::*;

  cmd_t                  mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_PTR_W:0]   cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign full_o    = (cnt_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (CMDQ_PTR_W+1)'(do_wr) - (CMDQ_PTR_W+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/core/hcis_back.sv =====
// Back end: sequencing state, command selection and result queue
`timescale 1ns / 1ps
`include "hci_reset_init_sequencer_defines.svh"
module hcis_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hcis_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [63:0]                        cfg_data_i,
  input  logic                               cmd_valid_i,
  input  hcis_pkg::cmd_t                     cmd_i,
  output logic                               cmd_pop_o,
  output logic                               empty_o,
  input  logic                               pop_i,
  output hcis_pkg::result_t                  result_o
);
  import hcis_pkg::*;

  logic [63:0] host_q;
  logic        ext_q;
  logic [63:0] feat_q, feat_d;
  logic [1:0]  rounds_q, rounds_d;
  logic        phase_q, phase_d;
  logic        busy, emit, out_wr, out_rd;
  result_t     res;
  result_t     out_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign busy = cmd_valid_i && (cnt_q != 2'd2);

  always_comb begin
    res       = '0;
    emit      = 1'b0;
    cmd_pop_o = 1'b0;
    phase_d   = phase_q;
    feat_d    = feat_q;
    rounds_d  = rounds_q;
    if (busy) begin
      emit      = 1'b1;
      cmd_pop_o = 1'b1;
      res.last  = 1'b1;
      unique case (cmd_i.cls)
        CLS_START: begin
          if (!phase_q) begin
            res.command_id = ID_RESET;
            res.last       = 1'b0;
            cmd_pop_o      = 1'b0;
            phase_d        = 1'b1;
          end else begin
            res.command_id = ID_VS_BDADDR;
            phase_d        = 1'b0;
          end
        end
        CLS_FIXED: begin
          res.command_id  = cmd_i.cmd_id;
          res.command_arg = cmd_i.arg;
        end
        CLS_RESET_DONE: begin
          rounds_d       = '0;
          res.command_id = ID_VS_NVDS;
        end
        CLS_FEATURES: begin
          feat_d = cmd_i.data;
          if (cmd_i.data[6] && host_q[6]) begin
            res.command_id = ID_LE_RLSIZE;
          end else if (cmd_i.data[5] && host_q[5]) begin
            res.command_id = ID_LE_MAXLEN;
          end else begin
            res.command_id = ID_LE_RAND;
          end
        end
        CLS_RLSIZE: begin
          res.command_id = (feat_q[5] && host_q[5]) ? ID_LE_MAXLEN : ID_LE_RAND;
        end
        CLS_RAND: begin
          if (rounds_q < RANDOM_ROUNDS) begin
            rounds_d       = rounds_q + 2'd1;
            res.command_id = ID_LE_RAND;
          end else begin
            res.action = ACT_DONE;
          end
        end
        CLS_MAXLEN: begin
          if (ext_q) begin
            res.action         = ACT_HANDOFF;
            res.handoff_opcode = cmd_i.opcode;
          end else begin
            res.command_id = ID_LE_RAND;
          end
        end
        CLS_HANDOFF: begin
          emit               = ext_q;
          res.action         = ACT_HANDOFF;
          res.handoff_opcode = cmd_i.opcode;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  assign out_wr   = emit;
  assign empty_o  = (cnt_q == 2'd0);
  assign out_rd   = pop_i && !empty_o;
  assign result_o = out_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_q   <= '0;
      ext_q    <= 1'b0;
      feat_q   <= '0;
      rounds_q <= '0;
      phase_q  <= 1'b0;
      wr_q     <= 1'b0;
      rd_q     <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_HOST_FEATURES) begin
        host_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_EXTENDED_PRESENT) begin
        ext_q <= cfg_data_i[0];
      end
      feat_q   <= feat_d;
      rounds_q <= rounds_d;
      phase_q  <= phase_d;
      if (out_wr) begin
        wr_q <= ~wr_q;
      end
      if (out_rd) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(out_wr) - 2'(out_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      out_q[wr_q] <= res;
    end
  end

  `HCIS_ASSERT(a_out_cnt, clk_i, rst_ni, cnt_q != 2'd3, "result queue overflow")
  `HCIS_ASSERT(a_rounds, clk_i, rst_ni, rounds_q <= RANDOM_ROUNDS, "round counter out of range")
  `HCIS_ASSERT(a_phase, clk_i, rst_ni, phase_q |-> (cmd_valid_i && cmd_i.cls == CLS_START), "start phase without start entry")
  `HCIS_ASSERT_ALWAYS(a_pop_space, clk_i, cmd_pop_o |-> (cmd_valid_i && cnt_q != 2'd2), "command popped without room")

endmodule

// ===== verif/tb_hci_reset_init_sequencer.sv =====
// Self-checking testbench for the HCI reset and initialisation sequencer
`timescale 1ns / 1ps
module tb_hci_reset_init_sequencer;
  import hcis_pkg::*;

  typedef struct {
    item_t   it;
    int      n;
    result_t e0;
    result_t e1;
  } vector_t;

  localparam logic [15:0] KNOWN_OPS [19] = '{
    OP_SET_EVMASK, OP_RESET, OP_SET_EVMASK_P2, OP_READ_VERSION, OP_READ_BDADDR,
    OP_LE_EVMASK, OP_LE_BUFSIZE, OP_LE_FEATURES, OP_LE_WLSIZE, OP_LE_RAND,
    OP_LE_STATES, OP_LE_MAXLEN, OP_LE_RLSIZE, OP_LE_RDDEFLEN, OP_LE_MAXADVLEN,
    OP_LE_NUMADVSETS, OP_LE_PERLISTSIZE, OP_VS_NVDS, OP_VS_RFPOWER
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b1;
  logic                 push_i      = 1'b0;
  logic                 full_o;
  item_t                item_i      = '0;
  logic                 empty_o;
  logic                 pop_i       = 1'b0;
  result_t              result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0]          cfg_data_i  = '0;

  // sequencer copy: configuration and captured controller data
  logic [63:0] host_mask;
  logic        handler_present;
  logic [63:0] ctrl_features;
  logic [7:0]  rl_size;
  logic [47:0] bd_addr;
  logic [15:0] acl_len;
  logic [7:0]  acl_count;
  logic [7:0]  acl_free;
  logic [7:0]  wl_size;
  logic [63:0] le_states;
  logic [31:0] max_octets_time;
  logic [1:0]  rand_rounds;

  result_t     next_cmds [2];
  int          next_count;
  result_t     awaited_cmds [$];
  vector_t     dir_rows [$];
  logic [15:0] follow_op;
  bit          need_start;
  bit          tx_calm;
  bit          rx_calm;
  int          results_seen;
  int          errors;

  hci_reset_init_sequencer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .item_i     (item_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic result_t mk(action_e a, cmd_id_e id, logic [31:0] arg,
                                 logic [15:0] op, logic last);
    result_t r;
    r.action         = a;
    r.command_id     = id;
    r.command_arg    = arg;
    r.handoff_opcode = op;
    r.last           = last;
    return r;
  endfunction

  function automatic logic gated(int b);
    return ctrl_features[b] & host_mask[b];
  endfunction

  function automatic cmd_id_e after_rl_size();
    return gated(5) ? ID_LE_MAXLEN : ID_LE_RAND;
  endfunction

  // work out the commands caused by one accepted item
  task automatic advance_sequencer(input item_t it);
    logic [63:0] p;
    p = it.return_params;
    next_count = 1;
    next_cmds[0] = '0;
    next_cmds[1] = '0;
    if (it.func == 1'b0) begin
      next_cmds[0] = mk(ACT_SEND, ID_RESET, '0, '0, 1'b0);
      next_cmds[1] = mk(ACT_SEND, ID_VS_BDADDR, '0, '0, 1'b1);
      next_count = 2;
    end else if (it.event_code != EVT_CMD_COMPLETE) begin
      next_count = 0;
    end else begin
      case (it.cmd_opcode)
        OP_SET_EVMASK: next_cmds[0] = mk(ACT_SEND, ID_LE_EVMASK, '0, '0, 1'b0);
        OP_RESET: begin
          rand_rounds = '0;
          next_cmds[0] = mk(ACT_SEND, ID_VS_NVDS, '0, '0, 1'b0);
        end
        OP_SET_EVMASK_P2: next_cmds[0] = mk(ACT_SEND, ID_READ_BDADDR, '0, '0, 1'b0);
        OP_READ_BDADDR: begin
          bd_addr = p[47:0];
          next_cmds[0] = mk(ACT_SEND, ID_LE_BUFSIZE, '0, '0, 1'b0);
        end
        OP_LE_EVMASK: next_cmds[0] = mk(ACT_SEND, ID_EVMASK_P2, '0, '0, 1'b0);
        OP_LE_BUFSIZE: begin
          acl_len   = p[15:0];
          acl_count = p[23:16];
          acl_free  = p[23:16];
          next_cmds[0] = mk(ACT_SEND, ID_LE_STATES, '0, '0, 1'b0);
        end
        OP_LE_FEATURES: begin
          ctrl_features = p;
          if (gated(6)) begin
            next_cmds[0] = mk(ACT_SEND, ID_LE_RLSIZE, '0, '0, 1'b0);
          end else begin
            rl_size = '0;
            next_cmds[0] = mk(ACT_SEND, after_rl_size(), '0, '0, 1'b0);
          end
        end
        OP_LE_WLSIZE: begin
          wl_size = p[7:0];
          next_cmds[0] = mk(ACT_SEND, ID_LE_FEATURES, '0, '0, 1'b0);
        end
        OP_LE_RAND: begin
          if (rand_rounds < RANDOM_ROUNDS) begin
            rand_rounds = rand_rounds + 2'd1;
            next_cmds[0] = mk(ACT_SEND, ID_LE_RAND, '0, '0, 1'b0);
          end else begin
            next_cmds[0] = mk(ACT_DONE, ID_RESET, '0, '0, 1'b0);
          end
        end
        OP_LE_STATES: begin
          le_states = p;
          next_cmds[0] = mk(ACT_SEND, ID_LE_WLSIZE, '0, '0, 1'b0);
        end
        OP_LE_MAXLEN: begin
          if (handler_present) begin
            next_cmds[0] = mk(ACT_HANDOFF, ID_RESET, '0, it.cmd_opcode, 1'b0);
          end else begin
            max_octets_time = '0;
            next_cmds[0] = mk(ACT_SEND, ID_LE_RAND, '0, '0, 1'b0);
          end
        end
        OP_LE_RLSIZE: begin
          rl_size = p[7:0];
          next_cmds[0] = mk(ACT_SEND, after_rl_size(), '0, '0, 1'b0);
        end
        OP_LE_RDDEFLEN: next_cmds[0] = mk(ACT_SEND, ID_LE_WRDEFLEN, p[31:0], '0, 1'b0);
        OP_VS_NVDS: next_cmds[0] = mk(ACT_SEND, ID_EVMASK, '0, '0, 1'b0);
        OP_VS_RFPOWER: next_cmds[0] = mk(ACT_SEND, ID_VS_RFPOWER, RF_POWER_LEVEL, '0, 1'b0);
        OP_READ_VERSION, OP_LE_MAXADVLEN, OP_LE_NUMADVSETS, OP_LE_PERLISTSIZE: begin
          if (handler_present)
            next_cmds[0] = mk(ACT_HANDOFF, ID_RESET, '0, it.cmd_opcode, 1'b0);
          else
            next_count = 0;
        end
        default: next_count = 0;
      endcase
      if (next_count == 1) next_cmds[0].last = 1'b1;
    end
  endtask

  function automatic logic [15:0] completion_of(cmd_id_e id);
    case (id)
      ID_RESET, ID_VS_BDADDR:   return OP_RESET;
      ID_VS_NVDS, ID_VS_RFPOWER: return OP_VS_NVDS;
      ID_EVMASK:                return OP_SET_EVMASK;
      ID_LE_EVMASK:             return OP_LE_EVMASK;
      ID_EVMASK_P2:             return OP_SET_EVMASK_P2;
      ID_READ_BDADDR:           return OP_READ_BDADDR;
      ID_LE_BUFSIZE:            return OP_LE_BUFSIZE;
      ID_LE_STATES:             return OP_LE_STATES;
      ID_LE_WLSIZE:             return OP_LE_WLSIZE;
      ID_LE_FEATURES:           return OP_LE_FEATURES;
      ID_LE_RLSIZE:             return OP_LE_RLSIZE;
      ID_LE_MAXLEN:             return OP_LE_MAXLEN;
      default:                  return OP_LE_RAND;
    endcase
  endfunction

  // mostly the completion the controller would send next, then noise
  function automatic item_t random_event();
    item_t it;
    int    sel;
    sel = $urandom_range(0, 99);
    it.func          = 1'b1;
    it.event_code    = EVT_CMD_COMPLETE;
    it.cmd_opcode    = follow_op;
    it.return_params = {$urandom(), $urandom()};
    if (need_start || sel < 5) begin
      it.func       = 1'b0;
      it.event_code = 8'($urandom_range(0, 255));
      it.cmd_opcode = 16'($urandom_range(0, 65535));
    end else if (sel < 75) begin
      it.cmd_opcode = follow_op;
    end else if (sel < 90) begin
      it.cmd_opcode = KNOWN_OPS[$urandom_range(0, 18)];
    end else if (sel < 95) begin
      it.event_code = 8'($urandom_range(0, 255));
      it.cmd_opcode = KNOWN_OPS[$urandom_range(0, 18)];
    end else begin
      it.event_code = 8'($urandom_range(0, 255));
      it.cmd_opcode = 16'($urandom_range(0, 65535));
    end
    return it;
  endfunction

  task automatic write_config(input logic [63:0] mask, input logic present);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_HOST_FEATURES;
    cfg_data_i  <= mask;
    do @(posedge clk_i); while (!cfg_ready_o);
    host_mask = mask;
    cfg_index_i <= CFG_EXTENDED_PRESENT;
    cfg_data_i  <= {63'd0, present};
    do @(posedge clk_i); while (!cfg_ready_o);
    handler_present = present;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(input item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full_o);
    advance_sequencer(it);
  endtask

  task automatic drain_to_idle();
    push_i <= 1'b0;
    while (awaited_cmds.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic add_row(input logic func, input logic [7:0] code, input logic [15:0] op,
                         input logic [63:0] p, input int n,
                         input result_t e0 = '0, input result_t e1 = '0);
    vector_t v;
    v.it = '{func: func, event_code: code, cmd_opcode: op, return_params: p};
    v.n  = n;
    v.e0 = e0;
    v.e1 = e1;
    dir_rows.push_back(v);
  endtask

  initial begin
    logic [63:0] phase_mask [7];
    logic        phase_ext [7];
    item_t       it;
    rst_ni <= 1'b0;
    host_mask = '0; handler_present = 1'b0; ctrl_features = '0; rl_size = '0;
    bd_addr = '0; acl_len = '0; acl_count = '0; acl_free = '0; wl_size = '0;
    le_states = '0; max_octets_time = '0; rand_rounds = '0;
    follow_op = OP_RESET; need_start = 1'b0; tx_calm = 1'b0; errors = 0;

    add_row(1'b0, 8'h00, 16'h0000, '0, 2, mk(ACT_SEND, ID_RESET, '0, '0, 1'b0),
            mk(ACT_SEND, ID_VS_BDADDR, '0, '0, 1'b1));
    add_row(1'b0, 8'hff, 16'hffff, '1, 2, mk(ACT_SEND, ID_RESET, '0, '0, 1'b0),
            mk(ACT_SEND, ID_VS_BDADDR, '0, '0, 1'b1));
    add_row(1'b1, 8'h00, OP_RESET, '0, 0);
    add_row(1'b1, 8'hff, OP_RESET, '1, 0);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_RESET, '0, 1,
            mk(ACT_SEND, ID_VS_NVDS, '0, '0, 1'b1));
    add_row(1'b1, EVT_CMD_COMPLETE, OP_VS_NVDS, '0, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_VS_RFPOWER, '1, 1,
            mk(ACT_SEND, ID_VS_RFPOWER, RF_POWER_LEVEL, '0, 1'b1));
    add_row(1'b1, EVT_CMD_COMPLETE, OP_SET_EVMASK, '0, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_LE_EVMASK, '0, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_SET_EVMASK_P2, '0, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_READ_BDADDR, '1, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_LE_BUFSIZE, '1, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_LE_STATES, '1, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_LE_WLSIZE, '1, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_LE_FEATURES, '1, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_LE_MAXLEN, '0, -1);
    repeat (5) add_row(1'b1, EVT_CMD_COMPLETE, OP_LE_RAND, '0, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_LE_RLSIZE, '1, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_LE_RDDEFLEN, '1, -1);
    add_row(1'b1, EVT_CMD_COMPLETE, OP_READ_VERSION, '0, 0);
    add_row(1'b1, EVT_CMD_COMPLETE, 16'h0000, '0, 0);
    add_row(1'b1, EVT_CMD_COMPLETE, 16'hffff, '1, 0);

    phase_mask = '{'1, {$urandom(), $urandom()}, 64'h60, {$urandom(), $urandom()},
                   '0, '1, 64'h40};
    phase_ext  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_config('0, 1'b0);

    foreach (dir_rows[i]) begin
      tx_calm = ($urandom_range(0, 2) == 0);
      send_item(dir_rows[i].it);
      if (dir_rows[i].n < 0) begin
        for (int k = 0; k < next_count; k++) awaited_cmds.push_back(next_cmds[k]);
      end else begin
        if (dir_rows[i].n > 0) awaited_cmds.push_back(dir_rows[i].e0);
        if (dir_rows[i].n > 1) awaited_cmds.push_back(dir_rows[i].e1);
      end
    end
    drain_to_idle();

    for (int ph = 0; ph < 7; ph++) begin
      write_config(phase_mask[ph], phase_ext[ph]);
      for (int k = 0; k < 85; k++) begin
        if (k % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        it = random_event();
        send_item(it);
        if (it.func == 1'b0) need_start = 1'b0;
        for (int r = 0; r < next_count; r++) awaited_cmds.push_back(next_cmds[r]);
        if (next_count > 0) begin
          case (next_cmds[next_count-1].action)
            ACT_SEND: follow_op = completion_of(next_cmds[next_count-1].command_id);
            ACT_DONE: need_start = 1'b1;
            default:  follow_op = KNOWN_OPS[$urandom_range(0, 18)];
          endcase
        end
      end
      drain_to_idle();
    end

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int  stall;
    bit  held;
    held    = 1'b0;
    rx_calm = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        pop_i <= 1'b0;
        stall = 0;
        while (stall < 300) begin
          @(posedge clk_i);
          stall++;
        end
      end else begin
        if (results_seen % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        stall = rx_calm ? 0 : $urandom_range(0, 11);
        if (stall > 0) begin
          pop_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      pop_i <= 1'b1;
      do @(posedge clk_i); while (empty_o);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop_i && !empty_o) begin
      results_seen++;
      if (awaited_cmds.size() == 0) begin
        $error("result with nothing awaited: %h", result_o);
        errors++;
      end else begin
        want = awaited_cmds.pop_front();
        if (result_o.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, result_o.action);
          errors++;
        end
        if (result_o.command_id !== want.command_id) begin
          $error("command_id: expected %0d, got %0d", want.command_id, result_o.command_id);
          errors++;
        end
        if (result_o.command_arg !== want.command_arg) begin
          $error("command_arg: expected %h, got %h", want.command_arg, result_o.command_arg);
          errors++;
        end
        if (result_o.handoff_opcode !== want.handoff_opcode) begin
          $error("handoff_opcode: expected %h, got %h", want.handoff_opcode,
                 result_o.handoff_opcode);
          errors++;
        end
        if (result_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result_o.last);
          errors++;
        end
      end
    end
  end

endmodule

// ===== hci_reset_init_sequencer.f =====
+incdir+rtl/core
rtl/core/hcis_pkg.sv
rtl/core/hcis_front.sv
rtl/core/hcis_cmd_fifo.sv
rtl/core/hcis_back.sv
rtl/core/hci_reset_init_sequencer.sv
verif/tb_hci_reset_init_sequencer.sv
